// ===== rtl/assert_macros.svh =====
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on clk, off while in reset
`define KHC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("keyed hash cache assertion failed");

// next-cycle implication
`define KHC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("keyed hash cache assertion failed");

`endif

// ===== rtl/khc_pkg.sv =====
// shared constants and types of the keyed hash cache
`default_nettype none

package khc_pkg;

  localparam int CACHE_ENTRIES = 16;
  localparam int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int CNT_W         = $clog2(CACHE_ENTRIES + 1);

  localparam int LANES         = 4;
  localparam int LANE_IDX_W    = $clog2(LANES);
  localparam int WORD_W        = 64;
  localparam int HALF_W        = WORD_W / 2;
  localparam int LANE_BYTES    = WORD_W / 8;
  localparam int BYTE_IDX_W    = $clog2(LANE_BYTES);
  localparam int NB_W          = $clog2(LANE_BYTES + 1);
  localparam int BLOCK_BYTES   = LANES * LANE_BYTES;
  localparam int VB_W          = 6;
  localparam int ENTRY_COUNT_W = 5;
  localparam int STEP_W        = 2;
  localparam logic [STEP_W-1:0] STEP_LAST = 2'd3;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_ADD    = 1'b1;

  typedef struct packed {
    logic              load;
    logic              fresh;
    logic              run;
    logic [STEP_W-1:0] step;
  } lane_ctl_t;

  typedef struct packed {
    logic cmp;
    logic upd;
    logic op;
  } cache_ctl_t;

  typedef struct packed {
    logic             hit;
    logic             ovf;
    logic [CNT_W-1:0] count;
  } cache_res_t;

endpackage

`default_nettype wire

// ===== rtl/khc_if.sv =====
// handshake channels of the keyed hash cache
`default_nettype none

interface khc_in_if;
  logic                       valid;
  logic                       ready;
  logic                       op;
  logic [khc_pkg::WORD_W-1:0] lane0;
  logic [khc_pkg::WORD_W-1:0] lane1;
  logic [khc_pkg::WORD_W-1:0] lane2;
  logic [khc_pkg::WORD_W-1:0] lane3;
  logic [khc_pkg::VB_W-1:0]   valid_bytes;
  logic                       last_block;

  modport source (output valid, op, lane0, lane1, lane2, lane3, valid_bytes, last_block,
                  input ready);
  modport sink (input valid, op, lane0, lane1, lane2, lane3, valid_bytes, last_block,
                output ready);
endinterface

interface khc_out_if;
  logic                              valid;
  logic                              ready;
  logic                              hit;
  logic                              overflowed;
  logic [khc_pkg::ENTRY_COUNT_W-1:0] entry_count;
  logic [khc_pkg::WORD_W-1:0]        message_hash;

  modport source (output valid, hit, overflowed, entry_count, message_hash, input ready);
  modport sink (input valid, hit, overflowed, entry_count, message_hash, output ready);
endinterface

interface khc_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [khc_pkg::WORD_W-1:0] nonce;

  modport source (output valid, nonce, input ready);
  modport sink (input valid, nonce, output ready);
endinterface

`default_nettype wire

// ===== rtl/khc_lane.sv =====
// one hash lane: byte merge and stepped multiply-xor mix
`default_nettype none

module khc_lane (
  input  wire                                 clk,
  input  wire khc_pkg::lane_ctl_t             ctl,
  input  wire [khc_pkg::LANE_IDX_W-1:0]       lane_idx,
  input  wire [khc_pkg::WORD_W-1:0]           nonce,
  input  wire [khc_pkg::WORD_W-1:0]           new_v,
  input  wire [khc_pkg::VB_W-1:0]             vb,
  output logic [khc_pkg::WORD_W-1:0]          hash
);

  logic [khc_pkg::WORD_W-1:0]  val_r, hash_r, sum_r, p_r;
  logic [khc_pkg::HALF_W-1:0]  q_r;
  logic [khc_pkg::WORD_W-1:0]  old_v, merged, prod, mixed;
  logic [khc_pkg::VB_W-1:0]    lo, diff;
  logic [khc_pkg::NB_W-1:0]    nb;
  logic [khc_pkg::HALF_W-1:0]  mul_a, mul_b;
  logic [khc_pkg::WORD_W-1:0]  mul_p;

  // bytes past the valid count keep the previous block's bytes, or are zero at a message start
  always_comb begin
    lo    = khc_pkg::VB_W'({lane_idx, {khc_pkg::BYTE_IDX_W{1'b0}}});
    diff  = vb - lo;
    old_v = ctl.fresh ? '0 : val_r;
    if (vb <= lo) begin
      nb = '0;
    end else if (diff >= khc_pkg::VB_W'(khc_pkg::LANE_BYTES)) begin
      nb = khc_pkg::NB_W'(khc_pkg::LANE_BYTES);
    end else begin
      nb = diff[khc_pkg::NB_W-1:0];
    end
    for (int b = 0; b < khc_pkg::LANE_BYTES; b++) begin
      merged[b*8 +: 8] = (khc_pkg::NB_W'(b) < nb) ? new_v[b*8 +: 8] : old_v[b*8 +: 8];
    end
  end

  // low 64 bits of hash*val from three 32x32 partial products
  always_comb begin
    mul_a = (ctl.step == 2'd2) ? hash_r[khc_pkg::WORD_W-1:khc_pkg::HALF_W]
                               : hash_r[khc_pkg::HALF_W-1:0];
    mul_b = (ctl.step == 2'd1) ? val_r[khc_pkg::WORD_W-1:khc_pkg::HALF_W]
                               : val_r[khc_pkg::HALF_W-1:0];
    mul_p = mul_a * mul_b;
    prod  = p_r + {q_r, {khc_pkg::HALF_W{1'b0}}};
    mixed = sum_r + {prod[khc_pkg::WORD_W-2:0], 1'b0};
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      val_r <= merged;
      if (ctl.fresh) begin
        hash_r <= nonce;
      end
    end else if (ctl.run) begin
      case (ctl.step)
        2'd0: begin
          p_r   <= mul_p;
          sum_r <= hash_r + val_r;
        end
        2'd1: q_r <= mul_p[khc_pkg::HALF_W-1:0];
        2'd2: q_r <= q_r + mul_p[khc_pkg::HALF_W-1:0];
        default: hash_r <= mixed ^ {{khc_pkg::HALF_W{1'b0}},
                                    mixed[khc_pkg::WORD_W-1:khc_pkg::HALF_W]};
      endcase
    end
  end

  assign hash = hash_r;

endmodule

`default_nettype wire

// ===== rtl/khc_cache.sv =====
// most-recently-used hash list: parallel match, then move or insert at front
`default_nettype none

module khc_cache (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire khc_pkg::cache_ctl_t      ctl,
  input  wire [khc_pkg::WORD_W-1:0]     hash,
  output khc_pkg::cache_res_t           res
);

  logic [khc_pkg::WORD_W-1:0]        ent_r [khc_pkg::CACHE_ENTRIES];
  logic [khc_pkg::CACHE_ENTRIES-1:0] match_r;
  logic [khc_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [khc_pkg::IDX_W-1:0]         pos;
  logic [khc_pkg::CNT_W-1:0]         shift;
  logic                              any_hit, full, do_write, ovf;

  always_comb begin
    pos = '0;
    for (int i = khc_pkg::CACHE_ENTRIES - 1; i >= 0; i--) begin
      if (match_r[i]) begin
        pos = khc_pkg::IDX_W'(i);
      end
    end
    any_hit  = |match_r;
    full     = (cnt_r >= khc_pkg::CNT_W'(khc_pkg::CACHE_ENTRIES));
    do_write = 1'b0;
    ovf      = 1'b0;
    shift    = '0;
    cnt_nxt  = cnt_r;
    if (ctl.op == khc_pkg::OP_LOOKUP) begin
      if (any_hit) begin
        do_write = 1'b1;
        shift    = khc_pkg::CNT_W'(pos);
      end
    end else if (!any_hit) begin
      do_write = 1'b1;
      if (full) begin
        ovf   = 1'b1;
        shift = khc_pkg::CNT_W'(khc_pkg::CACHE_ENTRIES - 1);
      end else begin
        shift   = cnt_r;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cmp) begin
      for (int i = 0; i < khc_pkg::CACHE_ENTRIES; i++) begin
        match_r[i] <= (ent_r[i] == hash) && (khc_pkg::CNT_W'(i) < cnt_r);
      end
    end
    if (ctl.upd && do_write) begin
      ent_r[0] <= hash;
      for (int i = 1; i < khc_pkg::CACHE_ENTRIES; i++) begin
        if (khc_pkg::CNT_W'(i) <= shift) begin
          ent_r[i] <= ent_r[i-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (ctl.upd) begin
      cnt_r <= cnt_nxt;
    end
  end

  assign res.hit   = any_hit;
  assign res.ovf   = ovf;
  assign res.count = ctl.upd ? cnt_nxt : cnt_r;

endmodule

`default_nettype wire

// ===== rtl/keyed_hash_lru_cache.sv =====
// keyed multiply-xor hash over four parallel lanes feeding a recently-used list
// one block: accept, then mix steps on the shared 32x32 multiplier per lane
// last block adds xor fold, match and update; update stalls while the output is held
// a new block is taken only in idle, once the previous block is fully done
// synchronous active-low reset: list empty, nonce 1, no message open, output empty
// the list storage has no reset; only entries below the count are ever matched
`default_nettype none

module keyed_hash_lru_cache (
  input  wire        clk,
  input  wire        rst_n,
  khc_in_if.sink     in_ch,
  khc_out_if.source  out_ch,
  khc_cfg_if.sink    cfg_ch
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MIX  = 5'b00010,
    S_XOR  = 5'b00100,
    S_CMP  = 5'b01000,
    S_UPD  = 5'b10000
  } state_t;

  state_t                                state_r, state_nxt;
  logic [khc_pkg::STEP_W-1:0]            step_r;
  logic                                  in_msg_r, last_r, op_r;
  logic [khc_pkg::WORD_W-1:0]            nonce_r, msg_hash_r;
  logic                                  out_valid_r, out_hit_r, out_ovf_r;
  logic [khc_pkg::ENTRY_COUNT_W-1:0]     out_count_r;
  logic [khc_pkg::WORD_W-1:0]            out_hash_r;
  logic                                  accept, upd_go;
  logic [khc_pkg::VB_W-1:0]              vb_sat;
  logic [khc_pkg::WORD_W-1:0]            lane_in   [khc_pkg::LANES];
  logic [khc_pkg::WORD_W-1:0]            lane_hash [khc_pkg::LANES];
  logic [khc_pkg::WORD_W-1:0]            folded;
  khc_pkg::lane_ctl_t                    lane_ctl;
  khc_pkg::cache_ctl_t                   cache_ctl;
  khc_pkg::cache_res_t                   cache_res;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign upd_go       = (state_r == S_UPD) && (!out_valid_r || out_ch.ready);

  assign vb_sat = (in_ch.valid_bytes > khc_pkg::VB_W'(khc_pkg::BLOCK_BYTES))
                ? khc_pkg::VB_W'(khc_pkg::BLOCK_BYTES) : in_ch.valid_bytes;

  assign lane_in[0] = in_ch.lane0;
  assign lane_in[1] = in_ch.lane1;
  assign lane_in[2] = in_ch.lane2;
  assign lane_in[3] = in_ch.lane3;

  assign lane_ctl.load  = accept;
  assign lane_ctl.fresh = !in_msg_r;
  assign lane_ctl.run   = (state_r == S_MIX);
  assign lane_ctl.step  = step_r;

  for (genvar g = 0; g < khc_pkg::LANES; g++) begin : g_lane
    khc_lane u_lane (
      .clk      (clk),
      .ctl      (lane_ctl),
      .lane_idx (khc_pkg::LANE_IDX_W'(g)),
      .nonce    (nonce_r),
      .new_v    (lane_in[g]),
      .vb       (vb_sat),
      .hash     (lane_hash[g])
    );
  end

  // merge the lanes into one message hash
  always_comb begin
    folded = '0;
    for (int i = 0; i < khc_pkg::LANES; i++) begin
      folded = folded ^ lane_hash[i];
    end
  end

  assign cache_ctl.cmp = (state_r == S_CMP);
  assign cache_ctl.upd = upd_go;
  assign cache_ctl.op  = op_r;

  khc_cache u_cache (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (cache_ctl),
    .hash  (msg_hash_r),
    .res   (cache_res)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_MIX;
      S_MIX: begin
        if (step_r == khc_pkg::STEP_LAST) begin
          state_nxt = last_r ? S_XOR : S_IDLE;
        end
      end
      S_XOR:  state_nxt = S_CMP;
      S_CMP:  state_nxt = S_UPD;
      S_UPD:  if (upd_go) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      in_msg_r    <= 1'b0;
      nonce_r     <= khc_pkg::WORD_W'(1);
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        nonce_r <= (cfg_ch.nonce == '0) ? khc_pkg::WORD_W'(1) : cfg_ch.nonce;
      end
      if (state_r == S_MIX) begin
        step_r <= step_r + 1'b1;
        if (step_r == khc_pkg::STEP_LAST) begin
          in_msg_r <= !last_r;
        end
      end else begin
        step_r <= '0;
      end
      if (upd_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= in_ch.last_block;
      op_r   <= in_ch.op;
    end
    if (state_r == S_XOR) begin
      msg_hash_r <= folded;
    end
    if (upd_go) begin
      out_hit_r   <= cache_res.hit;
      out_ovf_r   <= cache_res.ovf;
      out_count_r <= khc_pkg::ENTRY_COUNT_W'(cache_res.count);
      out_hash_r  <= msg_hash_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.hit          = out_hit_r;
  assign out_ch.overflowed   = out_ovf_r;
  assign out_ch.entry_count  = out_count_r;
  assign out_ch.message_hash = out_hash_r;

`include "assert_macros.svh"

  `KHC_ASSERT_NEXT(a_accept_mixes, accept, state_r == S_MIX)
  `KHC_ASSERT_IMPL(a_count_bound, 1'b1,
                   cache_res.count <= khc_pkg::CNT_W'(khc_pkg::CACHE_ENTRIES))
  `KHC_ASSERT_IMPL(a_ovf_only_add, upd_go && cache_res.ovf, op_r == khc_pkg::OP_ADD)
  `KHC_ASSERT_NEXT(a_upd_shows, upd_go, out_valid_r && (out_hash_r == $past(msg_hash_r)))

endmodule

`default_nettype wire
